/* sv/stq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and constants of the sorted timer event queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_BITS  = 16;
    localparam int TIME_BITS = 48;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    localparam int DELAY_BITS = 32;
    localparam int MS_BITS    = 10;
    localparam int PROD_BITS  = DELAY_BITS + MS_BITS;
    localparam int SUM_BITS   = ((TIME_BITS > PROD_BITS) ? TIME_BITS : PROD_BITS) + 1;

    localparam int SEC_BITS  = 29;
    localparam int USEC_BITS = 20;

    localparam logic [MS_BITS-1:0]   US_PER_MS = MS_BITS'(1000);
    localparam logic [USEC_BITS:0]   US_PER_S  = (USEC_BITS + 1)'(1000000);
    localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;

    // divide by one million as a shift by six, then a multiply by the
    // rounded-up reciprocal of 15625 that is exact over the shifted range
    localparam int          DIV_SHIFT     = 6;
    localparam int          US_ODD        = 1000000 / (1 << DIV_SHIFT);
    localparam int          DIV_X_BITS    = TIME_BITS - DIV_SHIFT;
    localparam int          RECIP_SHIFT   = DIV_X_BITS + $clog2(US_ODD);
    localparam logic [63:0] RECIP         = ((64'd1 << RECIP_SHIFT) + 64'(US_ODD - 1))
                                            / 64'(US_ODD);
    localparam int          RECIP_BITS    = $clog2(RECIP + 64'd1);
    localparam int          DIV_XL_BITS   = DIV_X_BITS / 2;
    localparam int          DIV_XH_BITS   = DIV_X_BITS - DIV_XL_BITS;
    localparam int          DIV_RL_BITS   = DIV_XL_BITS;
    localparam int          DIV_RH_BITS   = RECIP_BITS - DIV_RL_BITS;
    localparam int          DIV_PROD_BITS = DIV_X_BITS + RECIP_BITS;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]            operation;
        logic [TIME_BITS-1:0]  now_us;
        logic [DELAY_BITS-1:0] delay_ms;
        logic [TAG_BITS-1:0]   tag;
    } in_item_t;

    typedef struct packed {
        logic                  head_valid;
        logic [TIME_BITS-1:0]  head_deadline;
        logic [TAG_BITS-1:0]   head_tag;
        logic [SEC_BITS-1:0]   wait_seconds;
        logic [USEC_BITS-1:0]  wait_microseconds;
        logic [CNT_BITS-1:0]   entry_count;
        logic [1:0]            status;
    } result_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] deadline;
        logic [TAG_BITS-1:0]  tag;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctrl_t;

endpackage

/* sv/stq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_cell
// One slot of the sorted queue: holds an entry, shifts on insert or remove.
// ----------------------------------------------------------------------------
module stq_cell
(
    input  logic                clk,
    input  stq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  stq_pkg::entry_t     left_entry,
    input  logic                left_before,
    input  stq_pkg::entry_t     right_entry,
    output stq_pkg::entry_t     entry,
    output logic                ahead
);

    stq_pkg::entry_t entry_reg;
    stq_pkg::entry_t entry_next;

    // strictly earlier entries stay ahead, equal ones move behind the new one
    assign ahead = occupied && (entry_reg.deadline < ctrl.new_entry.deadline);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            stq_pkg::CELL_INSERT:
            begin
                if (!ahead)
                begin
                    if (left_before)
                        entry_next = ctrl.new_entry;
                    else
                        entry_next = left_entry;
                end
            end
            stq_pkg::CELL_REMOVE:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* sv/stq_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_divider
// Division of a time span by one million through a reciprocal multiply:
// split partial products, their sum, then the remainder, one stage each.
// ----------------------------------------------------------------------------
module stq_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic [stq_pkg::TIME_BITS-1:0]     dividend,
    output logic                              done,
    output logic [stq_pkg::SEC_BITS-1:0]      quotient,
    output logic [stq_pkg::USEC_BITS-1:0]     remainder
);

    logic [stq_pkg::DIV_XL_BITS-1:0]                     x_lo;
    logic [stq_pkg::DIV_XH_BITS-1:0]                     x_hi;
    logic [stq_pkg::DIV_RL_BITS-1:0]                     r_lo;
    logic [stq_pkg::DIV_RH_BITS-1:0]                     r_hi;

    logic [stq_pkg::DIV_XL_BITS+stq_pkg::DIV_RL_BITS-1:0] pp_ll_reg;
    logic [stq_pkg::DIV_XL_BITS+stq_pkg::DIV_RH_BITS-1:0] pp_lh_reg;
    logic [stq_pkg::DIV_XH_BITS+stq_pkg::DIV_RL_BITS-1:0] pp_hl_reg;
    logic [stq_pkg::DIV_XH_BITS+stq_pkg::DIV_RH_BITS-1:0] pp_hh_reg;
    logic [stq_pkg::USEC_BITS-1:0]                       low_reg;
    logic [stq_pkg::SEC_BITS-1:0]                        quo_reg;
    logic [stq_pkg::USEC_BITS-1:0]                       rem_reg;
    logic                                                mul_vld_reg;
    logic                                                sum_vld_reg;
    logic                                                done_reg;

    logic [stq_pkg::DIV_PROD_BITS-1:0]                   prod;
    logic [stq_pkg::USEC_BITS-1:0]                       quo_scaled;

    assign x_lo = stq_pkg::DIV_XL_BITS'(dividend >> stq_pkg::DIV_SHIFT);
    assign x_hi = stq_pkg::DIV_XH_BITS'(dividend >> (stq_pkg::DIV_SHIFT + stq_pkg::DIV_XL_BITS));
    assign r_lo = stq_pkg::DIV_RL_BITS'(stq_pkg::RECIP);
    assign r_hi = stq_pkg::DIV_RH_BITS'(stq_pkg::RECIP >> stq_pkg::DIV_RL_BITS);

    assign prod = stq_pkg::DIV_PROD_BITS'(pp_ll_reg)
                + (stq_pkg::DIV_PROD_BITS'(pp_lh_reg) << stq_pkg::DIV_RL_BITS)
                + (stq_pkg::DIV_PROD_BITS'(pp_hl_reg) << stq_pkg::DIV_XL_BITS)
                + (stq_pkg::DIV_PROD_BITS'(pp_hh_reg)
                   << (stq_pkg::DIV_XL_BITS + stq_pkg::DIV_RL_BITS));

    // only the low bits matter, the true remainder is below one million
    assign quo_scaled = quo_reg[stq_pkg::USEC_BITS-1:0]
                      * stq_pkg::USEC_BITS'(stq_pkg::US_PER_S);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            sum_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            mul_vld_reg <= go;
            sum_vld_reg <= mul_vld_reg;
            done_reg    <= sum_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            pp_ll_reg <= (stq_pkg::DIV_XL_BITS + stq_pkg::DIV_RL_BITS)'(x_lo)
                       * (stq_pkg::DIV_XL_BITS + stq_pkg::DIV_RL_BITS)'(r_lo);
            pp_lh_reg <= (stq_pkg::DIV_XL_BITS + stq_pkg::DIV_RH_BITS)'(x_lo)
                       * (stq_pkg::DIV_XL_BITS + stq_pkg::DIV_RH_BITS)'(r_hi);
            pp_hl_reg <= (stq_pkg::DIV_XH_BITS + stq_pkg::DIV_RL_BITS)'(x_hi)
                       * (stq_pkg::DIV_XH_BITS + stq_pkg::DIV_RL_BITS)'(r_lo);
            pp_hh_reg <= (stq_pkg::DIV_XH_BITS + stq_pkg::DIV_RH_BITS)'(x_hi)
                       * (stq_pkg::DIV_XH_BITS + stq_pkg::DIV_RH_BITS)'(r_hi);
            low_reg   <= dividend[stq_pkg::USEC_BITS-1:0];
        end
        if (mul_vld_reg)
            quo_reg <= stq_pkg::SEC_BITS'(prod >> stq_pkg::RECIP_SHIFT);
        if (sum_vld_reg)
            rem_reg <= low_reg - quo_scaled;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* sv/sorted_timer_event_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_event_queue
// Deadline-sorted event queue built as a row of shifting cells, with
// remaining-time report split into seconds and microseconds.
// ----------------------------------------------------------------------------
//  channel   signals               direction  handshake
//  command   start, busy, item     in         taken when start && !busy
//  result    done, result          out        one-cycle strobe on done
//
//  from the accept edge to the edge that takes its result, an item passes
//  through: multiply, saturating add, one cell-row shift, subtract, divider
//  launch, three divider stages, then the result register
//  busy falls in the cycle done is shown, so the next item may start then
//  reset clears the entry count and control; cell contents are left as is
//  the receiver cannot stall the result
// ----------------------------------------------------------------------------
module sorted_timer_event_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  stq_pkg::in_item_t  item,
    output logic               done,
    output stq_pkg::result_t   result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_UPD,
        ST_SUB,
        ST_GO,
        ST_DIV
    } state_t;

    state_t                            state_reg;
    stq_pkg::in_item_t                 item_reg;
    logic [stq_pkg::PROD_BITS-1:0]     prod_reg;
    logic [stq_pkg::TIME_BITS-1:0]     deadline_reg;
    logic [stq_pkg::CNT_BITS-1:0]      count_reg;
    logic [stq_pkg::TIME_BITS-1:0]     wait_reg;
    logic                              done_reg;
    stq_pkg::result_t                  result_reg;

    logic [stq_pkg::SUM_BITS-1:0]      sum;
    logic [stq_pkg::TIME_BITS-1:0]     sat_deadline;
    logic                              full;
    logic                              empty;
    stq_pkg::cell_ctrl_t               ctrl;

    stq_pkg::entry_t                   cell_entry [stq_pkg::DEPTH];
    logic [stq_pkg::DEPTH-1:0]         cell_before;
    logic [stq_pkg::DEPTH-1:0]         occupied;

    stq_pkg::entry_t                   head;
    logic                              head_valid;

    logic                              div_done;
    logic [stq_pkg::SEC_BITS-1:0]      div_quo;
    logic [stq_pkg::USEC_BITS-1:0]     div_rem;

    assign sum = stq_pkg::SUM_BITS'(item_reg.now_us) + stq_pkg::SUM_BITS'(prod_reg);
    // any carry past the time range saturates
    assign sat_deadline = (sum[stq_pkg::SUM_BITS-1:stq_pkg::TIME_BITS] != '0)
                          ? stq_pkg::TIME_MAX : sum[stq_pkg::TIME_BITS-1:0];

    assign full  = (count_reg == stq_pkg::CNT_BITS'(stq_pkg::DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        ctrl.new_entry.deadline = deadline_reg;
        ctrl.new_entry.tag      = item_reg.tag;
        ctrl.op                 = stq_pkg::CELL_HOLD;
        if (state_reg == ST_UPD)
        begin
            if (item_reg.operation == stq_pkg::OP_INSERT && !full)
                ctrl.op = stq_pkg::CELL_INSERT;
            else if (item_reg.operation == stq_pkg::OP_REMOVE && !empty)
                ctrl.op = stq_pkg::CELL_REMOVE;
        end
    end

    genvar i;
    generate
        for (i = 0; i < stq_pkg::DEPTH; i++)
        begin : g_cell
            stq_pkg::entry_t left_e;
            logic            left_b;
            stq_pkg::entry_t right_e;

            assign occupied[i] = (stq_pkg::CNT_BITS'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign left_e = ctrl.new_entry;
                assign left_b = 1'b1;
            end
            else
            begin : g_inner
                assign left_e = cell_entry[i-1];
                assign left_b = cell_before[i-1];
            end

            if (i == stq_pkg::DEPTH - 1)
            begin : g_last
                assign right_e = cell_entry[i];
            end
            else
            begin : g_mid
                assign right_e = cell_entry[i+1];
            end

            stq_cell u_cell
            (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied[i]),
                .left_entry  (left_e),
                .left_before (left_b),
                .right_entry (right_e),
                .entry       (cell_entry[i]),
                .ahead       (cell_before[i])
            );
        end
    endgenerate

    assign head       = cell_entry[0];
    assign head_valid = !empty;

    stq_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (state_reg == ST_GO),
        .dividend  (wait_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        item_reg  <= item;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= item_reg.delay_ms * stq_pkg::US_PER_MS;
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    deadline_reg <= sat_deadline;
                    state_reg    <= ST_UPD;
                end
                ST_UPD:
                begin
                    result_reg.status <= stq_pkg::STATUS_OK;
                    if (item_reg.operation == stq_pkg::OP_INSERT)
                    begin
                        if (full)
                            result_reg.status <= stq_pkg::STATUS_FULL;
                        else
                            count_reg <= count_reg + stq_pkg::CNT_BITS'(1);
                    end
                    else if (item_reg.operation == stq_pkg::OP_REMOVE)
                    begin
                        if (empty)
                            result_reg.status <= stq_pkg::STATUS_EMPTY;
                        else
                            count_reg <= count_reg - stq_pkg::CNT_BITS'(1);
                    end
                    state_reg <= ST_SUB;
                end
                ST_SUB:
                begin
                    result_reg.head_valid    <= head_valid;
                    result_reg.head_deadline <= head_valid ? head.deadline : '0;
                    result_reg.head_tag      <= head_valid ? head.tag : '0;
                    result_reg.entry_count   <= count_reg;
                    // an event already due reports zero wait
                    if (head_valid && head.deadline > item_reg.now_us)
                        wait_reg <= head.deadline - item_reg.now_us;
                    else
                        wait_reg <= '0;
                    state_reg <= ST_GO;
                end
                ST_GO:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        result_reg.wait_seconds      <= div_quo;
                        result_reg.wait_microseconds <= div_rem;
                        done_reg                     <= 1'b1;
                        state_reg                    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule
